// ===== hw/rtl/nmt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmt_pkg
// Shared constants and controller/datapath interface types for the neuron
// multiply-accumulate with tanh activation.
// ----------------------------------------------------------------------------
package nmt_pkg;

  localparam int DataWidthDefault = 16;  // default operand width
  localparam int FieldWidth       = 16;  // port width of activation, weight, bias
  localparam int AccWidth         = 32;  // accumulator and sum width
  localparam int CfgWidth         = 7;   // average_count register width
  localparam int OutWidth         = 8;   // neuron_out width
  localparam int RemWidth         = 7;   // divider remainder width, matches divisor

  localparam int BiasShift        = 7;   // bias*127 = (bias << 7) - bias
  localparam int TanhSat          = 16129;
  localparam int TanhMax          = 127;
  localparam int TanhK            = 260144641;
  localparam int TanhShift        = 35;
  localparam int XAbsWidth        = 14;  // |x| < 16129 fits 14 bits
  localparam int SqWidth          = 2 * XAbsWidth;
  localparam int OxWidth          = 28;  // TanhK < 2^28
  localparam int CubeWidth        = XAbsWidth + OxWidth;
  localparam int RWidth           = CubeWidth - TanhShift;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic mac_en;    // add product into the accumulator
    logic div_load;  // start division from the accumulator, clear it
    logic div_step;  // one quotient bit
    logic bias_en;   // apply sign to quotient and add bias*127
    logic abs_en;    // magnitude and saturation flags
    logic sq_en;     // square of the magnitude
    logic cube_en;   // magnitude times the odd polynomial term
    logic out_load;  // write the result register
  } nmt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_full;  // result register still holds an untaken result
  } nmt_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/nmt_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmt_div
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module nmt_div
  import nmt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic                step,
  input  wire logic [AccWidth-1:0] dividend,
  input  wire logic [CfgWidth-1:0] divisor,
  output logic      [AccWidth-1:0] quotient
);

  logic [RemWidth-1:0] rem;
  logic [CfgWidth-1:0] dvs;
  logic [AccWidth-1:0] quo;
  logic [RemWidth:0]   trial;
  logic                fits;

  assign trial = {rem, quo[AccWidth-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (step) begin
      rem <= fits ? RemWidth'(trial - {1'b0, dvs}) : trial[RemWidth-1:0];
      quo <= {quo[AccWidth-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// ===== hw/rtl/nmt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmt_dp
// Datapath: accumulator, divider, bias add, tanh stages and result register.
// ----------------------------------------------------------------------------
module nmt_dp
  import nmt_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDefault
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [FieldWidth-1:0] activation,
  input  wire logic [FieldWidth-1:0] weight,
  input  wire logic [FieldWidth-1:0] bias,
  input  wire logic                  cfg_we,
  input  wire logic [CfgWidth-1:0]   cfg_wdata,
  input  wire nmt_cmd_t              cmd,
  output nmt_sts_t                   sts,
  output logic      [OutWidth-1:0]   neuron_out,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  logic [CfgWidth-1:0]            average_count;
  logic signed [DATA_WIDTH-1:0]   act_s;
  logic signed [DATA_WIDTH-1:0]   wgt_s;
  logic signed [2*DATA_WIDTH-1:0] prod;
  logic [AccWidth-1:0]            acc;
  logic [DATA_WIDTH-1:0]          bias_q;
  logic                           sum_neg;
  logic [AccWidth-1:0]            sum_mag;
  logic [CfgWidth-1:0]            divisor;
  logic [AccWidth-1:0]            quotient;
  logic [AccWidth-1:0]            q_signed;
  logic signed [AccWidth-1:0]     bias_ext;
  logic [AccWidth-1:0]            bias_scaled;
  logic signed [AccWidth-1:0]     x;
  logic [AccWidth-1:0]            x_mag;
  logic                           x_neg;
  logic                           sat_pos;
  logic                           sat_neg;
  logic [XAbsWidth-1:0]           xabs;
  logic [SqWidth-1:0]             sq;
  logic [OxWidth-1:0]             ox;
  logic [CubeWidth-1:0]           cube;
  logic [OutWidth-1:0]            mag_out;
  logic [OutWidth-1:0]            result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      average_count <= CfgWidth'(1);
    end else if (cfg_we) begin
      average_count <= cfg_wdata;
    end
  end

  // multiply-accumulate
  assign act_s = activation[DATA_WIDTH-1:0];
  assign wgt_s = weight[DATA_WIDTH-1:0];
  assign prod  = act_s * wgt_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.mac_en) begin
      acc <= acc + AccWidth'(prod);
    end else if (cmd.div_load) begin
      acc <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      bias_q <= bias[DATA_WIDTH-1:0];
    end
    if (cmd.div_load) begin
      sum_neg <= acc[AccWidth-1];
    end
  end

  // divide magnitude, restore sign afterwards (truncates toward zero)
  assign sum_mag = acc[AccWidth-1] ? (~acc + AccWidth'(1)) : acc;
  assign divisor = (average_count == '0) ? CfgWidth'(1) : average_count;

  nmt_div u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (sum_mag),
    .divisor  (divisor),
    .quotient (quotient)
  );

  assign q_signed    = sum_neg ? (~quotient + AccWidth'(1)) : quotient;
  assign bias_ext    = AccWidth'($signed(bias_q));
  assign bias_scaled = AccWidth'(bias_ext <<< BiasShift) - AccWidth'(bias_ext);

  // tanh stages
  assign x_mag = x[AccWidth-1] ? AccWidth'(-x) : AccWidth'(x);
  assign ox    = OxWidth'(TanhK) - OxWidth'(sq >> 1);

  always_ff @(posedge clk) begin
    if (cmd.bias_en) begin
      x <= $signed(q_signed + bias_scaled);
    end
    if (cmd.abs_en) begin
      x_neg   <= x[AccWidth-1];
      sat_pos <= x >= $signed(AccWidth'(TanhSat));
      sat_neg <= x <= $signed(-AccWidth'(TanhSat));
      xabs    <= x_mag[XAbsWidth-1:0];
    end
    if (cmd.sq_en) begin
      sq <= xabs * xabs;
    end
    if (cmd.cube_en) begin
      cube <= CubeWidth'(xabs) * CubeWidth'(ox);
    end
  end

  assign mag_out = OutWidth'(cube[CubeWidth-1:TanhShift]);

  always_comb begin
    if (sat_pos) begin
      result = OutWidth'(TanhMax);
    end else if (sat_neg) begin
      result = OutWidth'(-TanhMax);
    end else if (x_neg) begin
      result = ~mag_out + OutWidth'(1);
    end else begin
      result = mag_out;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      neuron_out <= result;
    end
  end

  assign sts.out_full = out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/nmt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmt_ctrl
// Controller: sequences accumulation, division and tanh stages.
// ----------------------------------------------------------------------------
module nmt_ctrl
  import nmt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     last,
  output logic          in_ready,
  output nmt_cmd_t      cmd,
  input  wire nmt_sts_t sts
);

  localparam logic [2:0] StAccum = 3'd0;
  localparam logic [2:0] StLoad  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StBias  = 3'd3;
  localparam logic [2:0] StAbs   = 3'd4;
  localparam logic [2:0] StSq    = 3'd5;
  localparam logic [2:0] StCube  = 3'd6;
  localparam logic [2:0] StEmit  = 3'd7;

  localparam int DivSteps = AccWidth;
  localparam int CntWidth = $clog2(DivSteps);

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [CntWidth-1:0] count;
  logic [CntWidth-1:0] count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StAccum;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      StAccum: begin
        in_ready   = 1'b1;
        cmd.mac_en = in_valid;
        if (in_valid && last) begin
          state_next = StLoad;
        end
      end
      StLoad: begin
        cmd.div_load = 1'b1;
        count_next   = '0;
        state_next   = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        count_next   = count + CntWidth'(1);
        if (count == CntWidth'(DivSteps - 1)) begin
          state_next = StBias;
        end
      end
      StBias: begin
        cmd.bias_en = 1'b1;
        state_next  = StAbs;
      end
      StAbs: begin
        cmd.abs_en = 1'b1;
        state_next = StSq;
      end
      StSq: begin
        cmd.sq_en  = 1'b1;
        state_next = StCube;
      end
      StCube: begin
        cmd.cube_en = 1'b1;
        state_next  = StEmit;
      end
      StEmit: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = StAccum;
        end
      end
      default: begin
        state_next = StAccum;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/neuron_mac_tanh.sv =====
`default_nettype none
// Sequence: after the last item of a window is transferred: 1 load,
//   32 divider steps, bias add, 3 tanh stages, emit (waits while a result is held).
// Throughput: one item per cycle while accumulating; the serial divider,
//   one quotient bit per cycle, holds off new items after each last item until emit.
// Reset (synchronous): accumulator cleared, average_count = 1, no result held.
// ----------------------------------------------------------------------------
// neuron_mac_tanh
// Fixed-point neuron: multiply-accumulate, average, bias, cubic tanh.
// ----------------------------------------------------------------------------
module neuron_mac_tanh
  import nmt_pkg::*;
#(
  parameter int DATA_WIDTH = DataWidthDefault
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration: average_count
  input  wire logic                  cfg_we,
  input  wire logic [CfgWidth-1:0]   cfg_wdata,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [FieldWidth-1:0] activation,
  input  wire logic [FieldWidth-1:0] weight,
  input  wire logic [FieldWidth-1:0] bias,
  input  wire logic                  last,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [OutWidth-1:0]   neuron_out
);

  nmt_cmd_t cmd;
  nmt_sts_t sts;

  // Controller: accepts items only while accumulating; the result register
  // lets a new window start while the previous result waits for transfer.
  nmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: holds the accumulator, divider, tanh pipeline and result.
  nmt_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .activation (activation),
    .weight     (weight),
    .bias       (bias),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .neuron_out (neuron_out),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

endmodule
`default_nettype wire

// ===== bench/neuron_mac_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neuron_mac_checker
// Watches the configuration port and both handshake channels of
// neuron_mac_tanh. It predicts each neuron output from the transferred
// items and compares it with the results in order.
// ----------------------------------------------------------------------------
module neuron_mac_checker
  import nmt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CfgWidth-1:0]   cfg_wdata,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [FieldWidth-1:0] activation,
  input  wire logic [FieldWidth-1:0] weight,
  input  wire logic [FieldWidth-1:0] bias,
  input  wire logic                  last,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [OutWidth-1:0]   neuron_out,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint BiasScale = (longint'(1) << BiasShift) - 1;
  localparam int     MaxPrinted = 50;

  int                    mac_sum;       // wrapping 32-bit window sum
  logic [CfgWidth-1:0]   divisor_reg;   // copy of average_count
  logic [OutWidth-1:0]   expected_out_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    mac_sum         = 0;
    divisor_reg     = 1;
  end

  // Average, add the scaled bias, then the cubic tanh.
  function automatic logic [OutWidth-1:0] neuron_tanh(
    input int sum, input logic [CfgWidth-1:0] count, input logic [FieldWidth-1:0] b
  );
    longint divisor, quotient, xabs, odd_term, y;
    int     x;
    divisor  = (count == '0) ? longint'(1) : longint'(count);
    quotient = longint'(sum) / divisor;
    x        = int'(quotient + longint'($signed(b)) * BiasScale);
    if (x >= TanhSat) begin
      y = TanhMax;
    end else if (x <= -TanhSat) begin
      y = -TanhMax;
    end else begin
      xabs     = (x < 0) ? -longint'(x) : longint'(x);
      odd_term = longint'(TanhK) - ((xabs * xabs) >>> 1);
      y        = (xabs * odd_term) >>> TanhShift;
      if (x < 0) y = -y;
    end
    return y[OutWidth-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MaxPrinted) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [OutWidth-1:0] want;
    if (rst) begin
      mac_sum     = 0;
      divisor_reg = 1;
      expected_out_q.delete();
    end else begin
      if (cfg_we) divisor_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        mac_sum = mac_sum + int'(longint'($signed(activation)) * longint'($signed(weight)));
        if (last) begin
          expected_out_q.push_back(neuron_tanh(mac_sum, divisor_reg, bias));
          mac_sum = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result neuron_out=%0d",
                                    $signed(neuron_out)));
        end else begin
          want = expected_out_q.pop_front();
          results_checked++;
          if (neuron_out !== want)
            report_mismatch($sformatf("result %0d: neuron_out=%0d, want %0d",
                                      results_checked, $signed(neuron_out),
                                      $signed(want)));
        end
      end
    end
    pending = expected_out_q.size();
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives windows of activation/weight items into neuron_mac_tanh across a
// range of average_count settings and idle profiles; a checker beside the
// block predicts every neuron output and counts mismatches.
// ----------------------------------------------------------------------------
module testbench
  import nmt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 4000;  // cycles without any transfer
  localparam int DrainCycles   = 50;    // idle wait after the last predicted output
  localparam int NumPhases     = 9;
  localparam int PhaseItems    = 140;
  localparam int LongStall     = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CfgWidth-1:0]   cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FieldWidth-1:0] activation = '0;
  logic [FieldWidth-1:0] weight = '0;
  logic [FieldWidth-1:0] bias = '0;
  logic                  last = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OutWidth-1:0]   neuron_out;

  int chk_fails, chk_pending, chk_results;

  // Idle chances in percent; the receiver process reads its own each cycle.
  int send_idle_pct  = 38;
  int recv_idle_pct  = 84;
  int long_stall_req = 0;
  int items_sent     = 0;
  int settings_used  = 0;

  neuron_mac_tanh dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .activation (activation),
    .weight     (weight),
    .bias       (bias),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .neuron_out (neuron_out)
  );

  neuron_mac_checker chk (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .activation      (activation),
    .weight          (weight),
    .bias            (bias),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .neuron_out      (neuron_out),
    .fail_count      (chk_fails),
    .pending         (chk_pending),
    .results_checked (chk_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: drop ready at random, or hold it low for a long stretch when
  // asked, counting that stretch here so the sender keeps pushing meanwhile.
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (long_stall_req > 0) begin
        hold           = long_stall_req;
        long_stall_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run once nothing has been transferred for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no transfer for %0d cycles", WatchdogLimit);
    $display("Verification failed");
    $finish;
  end

  // Offer one item from a falling edge and hold it until the transfer;
  // return on the falling edge after it.
  task automatic send_item(input int a, input int w, input int b, input bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    activation <= a[FieldWidth-1:0];
    weight     <= w[FieldWidth-1:0];
    bias       <= b[FieldWidth-1:0];
    last       <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop offering, wait for every predicted output, then let the divider
  // and tanh pipeline run dry before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_count(input logic [CfgWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Field value by flavor: small and mid draw from +/- span, full hits every bit,
  // corner picks the two's complement edges.
  function automatic int pick_field(input int flavor, input int span);
    int corner;
    case (flavor)
      0, 1: begin
        return int'($urandom_range(2 * span)) - span;
      end
      2: begin
        return int'($urandom_range(65535)) - 32768;
      end
      default: begin
        corner = $urandom_range(4);
        case (corner)
          0:       return -32768;
          1:       return 32767;
          2:       return 0;
          3:       return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // One neuron window of random length and flavor, closed by a last item.
  task automatic send_window();
    int len, roll, flavor, a_span, w_span, b_span, i;
    roll = $urandom_range(99);
    if (roll < 70)      len = $urandom_range(1, 8);
    else if (roll < 95) len = $urandom_range(9, 32);
    else                len = $urandom_range(33, 100);
    roll = $urandom_range(99);
    if (roll < 50)      flavor = 0;
    else if (roll < 70) flavor = 1;
    else if (roll < 90) flavor = 2;
    else                flavor = 3;
    a_span = (flavor == 0) ? 255 : 2047;
    w_span = (flavor == 0) ? 63  : 2047;
    b_span = (flavor == 0) ? 127 : 255;
    for (i = 0; i < len; i++)
      send_item(pick_field(flavor, a_span), pick_field(flavor, w_span),
                pick_field(flavor, b_span), i == len - 1);
  endtask

  // Edges of the fields, saturation boundaries and wraparound, all at the
  // reset divisor of one.
  task automatic run_directed();
    send_item(0, 0, 0, 1'b1);
    send_item(32767, 32767, 32767, 1'b1);
    send_item(-32768, 32767, -32768, 1'b1);
    send_item(-32768, -32768, 32767, 1'b1);
    // accumulator wraps: three times 2^30 turns negative
    send_item(-32768, -32768, 0, 1'b0);
    send_item(-32768, -32768, 0, 1'b0);
    send_item(-32768, -32768, 0, 1'b0);
    send_item(0, 0, 0, 1'b1);
    // bias add wraps: sum just under 2^31 plus a large positive bias
    send_item(-32768, -32768, 0, 1'b0);
    send_item(32767, 32767, 32767, 1'b1);
    // inside the curve and at the saturation threshold on both sides
    send_item(100, 100, 0, 1'b1);
    send_item(-100, 100, 0, 1'b1);
    send_item(1, 1, 0, 1'b1);
    send_item(16128, 1, 0, 1'b1);
    send_item(-16128, 1, 0, 1'b1);
    send_item(0, 0, 127, 1'b1);
    send_item(0, 0, -127, 1'b1);
    send_item(1, -1, 0, 1'b1);
    send_item(-1, -1, -1, 1'b1);
    send_item(255, 63, -64, 1'b1);
  endtask

  initial begin : stimulus
    logic [CfgWidth-1:0] count_plan[NumPhases];
    int phase, budget;

    // Divisor edges: both ends of the usual range, zero, the register top
    // and just past the usual range.
    count_plan[0] = 4;
    count_plan[1] = 64;
    count_plan[2] = 0;
    count_plan[3] = 127;
    count_plan[4] = 1;
    count_plan[5] = 65;
    count_plan[6] = CfgWidth'($urandom_range(2, 63));
    count_plan[7] = 3;
    count_plan[8] = 1;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      // Idle profile: sender-light first, then receiver-light, then none.
      if (phase < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 84;
      end else if (phase < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_count(count_plan[phase]);
      // Back-pressure: block the output while items keep coming.
      if (phase == 6) long_stall_req = LongStall;
      budget = items_sent + PhaseItems;
      while (items_sent < budget) send_window();
    end

    settle();

    $display("Covered %0d items and %0d neuron outputs over %0d divisor settings,",
             items_sent, chk_results, settings_used);
    $display("three idle profiles and one long output stall; %0d mismatches",
             chk_fails);
    if (chk_fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
